@@ src/dhlpq_pkg.sv @@
// Package for the DH link pose block: link constant table, arctangent table,
// fixed-point constants and rounding helpers. No dependencies.
package dhlpq_pkg;

    localparam int ATAN_ROWS = 20;

    localparam logic [1:0] ALPHA_ZERO = 2'd0;
    localparam logic [1:0] ALPHA_POS  = 2'd1;
    localparam logic [1:0] ALPHA_NEG  = 2'd2;

    localparam logic signed [33:0] HALF_PI_Q30   = 34'sd1686629713;
    localparam logic signed [33:0] PI_Q30        = 34'sd3373259426;
    localparam logic signed [31:0] CORDIC_X0     = 32'sd268435456;
    localparam logic signed [16:0] ROOT_HALF_Q14 = 17'sd11585;
    localparam logic signed [34:0] QUARTER_Q28   = -35'sd134217728;

    typedef logic signed [15:0] t_q16;

    typedef struct packed {
        logic       vld;
        logic       bad;
        logic [2:0] idx;
    } t_side;

    function automatic t_q16 link_a(input logic [2:0] idx);
        case (idx)
            3'd2:    link_a = 16'sd2703;
            3'd3:    link_a = -16'sd2703;
            3'd5:    link_a = 16'sd2884;
            default: link_a = 16'sd0;
        endcase
    endfunction

    function automatic t_q16 link_d(input logic [2:0] idx);
        case (idx)
            3'd0:    link_d = 16'sd10912;
            3'd2:    link_d = 16'sd10355;
            3'd4:    link_d = 16'sd12583;
            3'd6:    link_d = 16'sd3506;
            default: link_d = 16'sd0;
        endcase
    endfunction

    function automatic logic [1:0] link_alpha(input logic [2:0] idx);
        case (idx)
            3'd0, 3'd3:             link_alpha = ALPHA_NEG;
            3'd1, 3'd2, 3'd4, 3'd5: link_alpha = ALPHA_POS;
            default:                link_alpha = ALPHA_ZERO;
        endcase
    endfunction

    function automatic logic signed [33:0] atan_q30(input logic [4:0] i);
        case (i)
            5'd0:    atan_q30 = 34'sh03243F6A8;
            5'd1:    atan_q30 = 34'sh01DAC6705;
            5'd2:    atan_q30 = 34'sh00FADBAFC;
            5'd3:    atan_q30 = 34'sh007F56EA6;
            5'd4:    atan_q30 = 34'sh003FEAB76;
            5'd5:    atan_q30 = 34'sh001FFD55B;
            5'd6:    atan_q30 = 34'sh000FFFAAA;
            5'd7:    atan_q30 = 34'sh0007FFF55;
            5'd8:    atan_q30 = 34'sh0003FFFEA;
            5'd9:    atan_q30 = 34'sh0001FFFFD;
            5'd10:   atan_q30 = 34'sh0000FFFFF;
            5'd11:   atan_q30 = 34'sh00007FFFF;
            5'd12:   atan_q30 = 34'sh00003FFFF;
            5'd13:   atan_q30 = 34'sh00001FFFF;
            5'd14:   atan_q30 = 34'sh00000FFFF;
            5'd15:   atan_q30 = 34'sh000007FFF;
            5'd16:   atan_q30 = 34'sh000003FFF;
            5'd17:   atan_q30 = 34'sh000001FFF;
            5'd18:   atan_q30 = 34'sh000000FFF;
            5'd19:   atan_q30 = 34'sh0000007FF;
            default: atan_q30 = 34'sh000000000;
        endcase
    endfunction

    // round to nearest, halves away from zero, keep low 16 bits
    function automatic t_q16 round_sh28(input logic signed [47:0] v);
        logic signed [47:0] t;
        if (v >= 0) begin
            t = (v + 48'sd134217728) >>> 28;
        end else begin
            t = -((-v + 48'sd134217728) >>> 28);
        end
        round_sh28 = t[15:0];
    endfunction

    function automatic t_q16 round_sh14(input logic signed [33:0] v);
        logic signed [33:0] t;
        if (v >= 0) begin
            t = (v + 34'sd8192) >>> 14;
        end else begin
            t = -((-v + 34'sd8192) >>> 14);
        end
        round_sh14 = t[15:0];
    endfunction

endpackage

@@ src/dhlpq_if.sv @@
// Valid/ready channel interfaces for the DH link pose block.
// Input carries the joint index and angle; output carries pose and flag.
interface dhlpq_in_if;
    logic               valid;
    logic               ready;
    logic [2:0]         joint_index;
    logic signed [15:0] joint_angle;

    modport source (output valid, joint_index, joint_angle, input ready);
    modport sink   (input valid, joint_index, joint_angle, output ready);
endinterface

interface dhlpq_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic               bad_index;

    modport source (output valid, pos_x, pos_y, pos_z, quat_w, quat_x, quat_y, quat_z,
                    bad_index, input ready);
    modport sink   (input valid, pos_x, pos_y, pos_z, quat_w, quat_x, quat_y, quat_z,
                    bad_index, output ready);
endinterface

@@ src/dh_link_pose_quaternion.sv @@
// DH link pose: pipelined CORDIC, square root and divider to the link pose.
// Depends on dhlpq_pkg and the channel interfaces in dhlpq_if.sv.
//
// One item is taken per clock while the output transfer is not stalled. The
// pipeline has ROTATOR_STAGES + 56 register stages: one per CORDIC iteration,
// one per root bit (31), one per quotient bit (16), and nine more for angle
// reduction, squaring, the sum of squares, divider setup, sign restore,
// products, combination, quaternion sign and output. The whole pipeline
// holds while the output transfer is stalled; the output register is the
// last stage. Indexes at or above JOINT_COUNT return all-zero pose with
// bad_index set.
module dh_link_pose_quaternion #(
    parameter int JOINT_COUNT    = 7,
    parameter int ROTATOR_STAGES = 14
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dhlpq_in_if.sink    i_item,
    dhlpq_out_if.source o_result
);
    import dhlpq_pkg::*;

    localparam int RS    = ROTATOR_STAGES;
    localparam int SQ0   = RS + 1;
    localparam int SUM   = RS + 2;
    localparam int SQN   = 31;
    localparam int SQE   = SUM + SQN;
    localparam int DV0   = SQE + 1;
    localparam int DVN   = 16;
    localparam int DVE   = DV0 + DVN;
    localparam int SGN   = DVE + 1;
    localparam int PRD   = SGN + 1;
    localparam int CMB   = PRD + 1;
    localparam int QST   = CMB + 1;
    localparam int LAT   = QST + 1;

    t_side r_sd [0:LAT];
    logic  w_adv;

    // angle reduction
    logic signed [33:0] w_ang;
    logic signed [33:0] w_ang_red;
    logic               w_flip;

    logic signed [31:0] r_cx [0:RS];
    logic signed [31:0] r_cy [0:RS];
    logic signed [33:0] r_ca [0:RS];
    logic               r_cf [0:RS];

    logic signed [63:0] w_sqx;
    logic signed [63:0] w_sqy;
    logic [61:0]        r_sqx;
    logic [61:0]        r_sqy;
    logic signed [31:0] r_px [SQ0:SQE];
    logic signed [31:0] r_py [SQ0:SQE];
    logic [61:0]        r_sv [SUM:SQE];
    logic [61:0]        r_sr [SUM:SQE];

    logic [30:0]        w_root;
    logic [30:0]        w_div;
    logic [31:0]        w_ax;
    logic [31:0]        w_ay;
    logic [46:0]        r_nc [DV0:DVE];
    logic [46:0]        r_ns [DV0:DVE];
    logic [30:0]        r_dv [DV0:DVE];
    logic [15:0]        r_qc [DV0:DVE];
    logic [15:0]        r_qs [DV0:DVE];
    logic               r_sx [DV0:DVE];
    logic               r_sy [DV0:DVE];

    logic signed [16:0] r_c [SGN:CMB];
    logic signed [16:0] r_s [SGN:CMB];
    logic signed [33:0] r_cc;
    logic signed [33:0] r_ss;
    logic signed [33:0] r_cs;
    logic signed [33:0] r_ch;
    logic signed [33:0] r_sh;
    logic signed [34:0] r_ct;
    logic signed [34:0] r_st;
    t_q16               r_p;
    t_q16               r_q2;

    logic signed [47:0] r_ax;
    logic signed [47:0] r_ay;
    t_q16               r_d;
    t_q16               r_qv [0:3];
    logic [1:0]         w_alpha;
    t_q16               w_qv [0:3];
    logic [1:0]         w_piv;

    t_q16 r_o_px, r_o_py, r_o_pz, r_o_qw, r_o_qx, r_o_qy, r_o_qz;

    assign w_adv        = !r_sd[LAT].vld || o_result.ready;
    assign i_item.ready = w_adv;

    assign w_ang = {i_item.joint_angle[15], i_item.joint_angle, 17'd0};

    always_comb begin
        w_ang_red = w_ang;
        w_flip    = 1'b0;
        if (w_ang > HALF_PI_Q30) begin
            w_ang_red = w_ang - PI_Q30;
            w_flip    = 1'b1;
        end else if (w_ang < -HALF_PI_Q30) begin
            w_ang_red = w_ang + PI_Q30;
            w_flip    = 1'b1;
        end
    end

    assign w_sqx  = 64'(r_cx[RS]) * 64'(r_cx[RS]);
    assign w_sqy  = 64'(r_cy[RS]) * 64'(r_cy[RS]);
    assign w_root = r_sr[SQE][30:0];
    assign w_div  = (w_root == 31'd0) ? 31'd1 : w_root;
    assign w_ax   = r_px[SQE][31] ? 32'(-r_px[SQE]) : 32'(r_px[SQE]);
    assign w_ay   = r_py[SQE][31] ? 32'(-r_py[SQE]) : 32'(r_py[SQE]);

    // quaternion before sign fix and the component whose sign decides
    always_comb begin
        w_alpha = link_alpha(r_sd[CMB].idx);
        if (w_alpha == ALPHA_ZERO) begin
            w_qv[0] = r_c[CMB][15:0];
            w_qv[1] = 16'sd0;
            w_qv[2] = 16'sd0;
            w_qv[3] = r_s[CMB][15:0];
            w_piv   = (r_ct > QUARTER_Q28) ? 2'd0 : 2'd3;
        end else begin
            w_qv[0] = r_p;
            w_qv[3] = r_q2;
            w_qv[1] = (w_alpha == ALPHA_POS) ? r_p : -r_p;
            w_qv[2] = (w_alpha == ALPHA_POS) ? r_q2 : -r_q2;
            if (r_ct > 0) begin
                w_piv = 2'd0;
            end else if (r_ct < 0) begin
                w_piv = 2'd2;
            end else begin
                w_piv = 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= LAT; k++) begin
                r_sd[k].vld <= 1'b0;
            end
        end else if (w_adv) begin
            r_sd[0].vld <= i_item.valid;
            for (int k = 1; k <= LAT; k++) begin
                r_sd[k].vld <= r_sd[k-1].vld;
            end
        end

        if (w_adv) begin
            r_sd[0].idx <= i_item.joint_index;
            r_sd[0].bad <= (i_item.joint_index >= 3'(JOINT_COUNT));
            for (int k = 1; k <= LAT; k++) begin
                r_sd[k].idx <= r_sd[k-1].idx;
                r_sd[k].bad <= r_sd[k-1].bad;
            end

            r_cx[0] <= CORDIC_X0;
            r_cy[0] <= 32'sd0;
            r_ca[0] <= w_ang_red;
            r_cf[0] <= w_flip;
            for (int k = 1; k <= RS; k++) begin
                r_cf[k] <= r_cf[k-1];
                if (r_ca[k-1] >= 0) begin
                    r_cx[k] <= r_cx[k-1] - (r_cy[k-1] >>> (k - 1));
                    r_cy[k] <= r_cy[k-1] + (r_cx[k-1] >>> (k - 1));
                    r_ca[k] <= r_ca[k-1] - atan_q30(5'(k - 1));
                end else begin
                    r_cx[k] <= r_cx[k-1] + (r_cy[k-1] >>> (k - 1));
                    r_cy[k] <= r_cy[k-1] - (r_cx[k-1] >>> (k - 1));
                    r_ca[k] <= r_ca[k-1] + atan_q30(5'(k - 1));
                end
            end

            // undo the half-turn reduction; squares do not see the sign
            r_px[SQ0] <= r_cf[RS] ? -r_cx[RS] : r_cx[RS];
            r_py[SQ0] <= r_cf[RS] ? -r_cy[RS] : r_cy[RS];
            r_sqx     <= w_sqx[61:0];
            r_sqy     <= w_sqy[61:0];

            r_sv[SUM] <= r_sqx + r_sqy;
            r_sr[SUM] <= 62'd0;
            for (int k = SUM; k <= SQE; k++) begin
                if (k > SQ0) begin
                    r_px[k] <= r_px[k-1];
                    r_py[k] <= r_py[k-1];
                end
            end

            // one root bit per stage
            for (int j = 0; j < SQN; j++) begin
                if (r_sv[SUM+j] >= r_sr[SUM+j] + (62'd1 << (60 - 2 * j))) begin
                    r_sv[SUM+j+1] <= r_sv[SUM+j] - (r_sr[SUM+j] + (62'd1 << (60 - 2 * j)));
                    r_sr[SUM+j+1] <= (r_sr[SUM+j] >> 1) + (62'd1 << (60 - 2 * j));
                end else begin
                    r_sv[SUM+j+1] <= r_sv[SUM+j];
                    r_sr[SUM+j+1] <= r_sr[SUM+j] >> 1;
                end
            end

            r_nc[DV0] <= (47'(w_ax) << 14) + 47'(w_div >> 1);
            r_ns[DV0] <= (47'(w_ay) << 14) + 47'(w_div >> 1);
            r_dv[DV0] <= w_div;
            r_qc[DV0] <= 16'd0;
            r_qs[DV0] <= 16'd0;
            r_sx[DV0] <= r_px[SQE][31];
            r_sy[DV0] <= r_py[SQE][31];

            // one quotient bit per stage, most significant first
            for (int j = 0; j < DVN; j++) begin
                r_dv[DV0+j+1] <= r_dv[DV0+j];
                r_sx[DV0+j+1] <= r_sx[DV0+j];
                r_sy[DV0+j+1] <= r_sy[DV0+j];
                if (r_nc[DV0+j] >= (47'(r_dv[DV0+j]) << (DVN - 1 - j))) begin
                    r_nc[DV0+j+1] <= r_nc[DV0+j] - (47'(r_dv[DV0+j]) << (DVN - 1 - j));
                    r_qc[DV0+j+1] <= r_qc[DV0+j] | (16'd1 << (DVN - 1 - j));
                end else begin
                    r_nc[DV0+j+1] <= r_nc[DV0+j];
                    r_qc[DV0+j+1] <= r_qc[DV0+j];
                end
                if (r_ns[DV0+j] >= (47'(r_dv[DV0+j]) << (DVN - 1 - j))) begin
                    r_ns[DV0+j+1] <= r_ns[DV0+j] - (47'(r_dv[DV0+j]) << (DVN - 1 - j));
                    r_qs[DV0+j+1] <= r_qs[DV0+j] | (16'd1 << (DVN - 1 - j));
                end else begin
                    r_ns[DV0+j+1] <= r_ns[DV0+j];
                    r_qs[DV0+j+1] <= r_qs[DV0+j];
                end
            end

            r_c[SGN] <= r_sx[DVE] ? -$signed({1'b0, r_qc[DVE]}) : $signed({1'b0, r_qc[DVE]});
            r_s[SGN] <= r_sy[DVE] ? -$signed({1'b0, r_qs[DVE]}) : $signed({1'b0, r_qs[DVE]});

            r_cc <= 34'(r_c[SGN]) * 34'(r_c[SGN]);
            r_ss <= 34'(r_s[SGN]) * 34'(r_s[SGN]);
            r_cs <= 34'(r_c[SGN]) * 34'(r_s[SGN]);
            r_ch <= 34'(r_c[SGN]) * 34'(ROOT_HALF_Q14);
            r_sh <= 34'(r_s[SGN]) * 34'(ROOT_HALF_Q14);
            r_c[PRD] <= r_c[SGN];
            r_s[PRD] <= r_s[SGN];

            r_ct <= 35'(r_cc) - 35'(r_ss);
            r_st <= 35'(r_cs) <<< 1;
            r_p  <= round_sh14(r_ch);
            r_q2 <= round_sh14(r_sh);
            r_c[CMB] <= r_c[PRD];
            r_s[CMB] <= r_s[PRD];

            r_ax <= 48'(link_a(r_sd[CMB].idx)) * 48'(r_ct);
            r_ay <= 48'(link_a(r_sd[CMB].idx)) * 48'(r_st);
            r_d  <= link_d(r_sd[CMB].idx);
            for (int i = 0; i < 4; i++) begin
                r_qv[i] <= w_qv[w_piv][15] ? -w_qv[i] : w_qv[i];
            end

            // drop everything for an index outside the table
            if (r_sd[QST].bad) begin
                r_o_px <= 16'sd0;
                r_o_py <= 16'sd0;
                r_o_pz <= 16'sd0;
                r_o_qw <= 16'sd0;
                r_o_qx <= 16'sd0;
                r_o_qy <= 16'sd0;
                r_o_qz <= 16'sd0;
            end else begin
                r_o_px <= round_sh28(r_ax);
                r_o_py <= round_sh28(r_ay);
                r_o_pz <= r_d;
                r_o_qw <= r_qv[0];
                r_o_qx <= r_qv[1];
                r_o_qy <= r_qv[2];
                r_o_qz <= r_qv[3];
            end
        end
    end

    assign o_result.valid     = r_sd[LAT].vld;
    assign o_result.bad_index = r_sd[LAT].bad;
    assign o_result.pos_x     = r_o_px;
    assign o_result.pos_y     = r_o_py;
    assign o_result.pos_z     = r_o_pz;
    assign o_result.quat_w    = r_o_qw;
    assign o_result.quat_x    = r_o_qx;
    assign o_result.quat_y    = r_o_qy;
    assign o_result.quat_z    = r_o_qz;

    // CORDIC gain keeps the root far from zero for every angle
    a_root_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sd[SQE].vld |-> r_sr[SQE] != 62'd0)
        else $error("square root of rotator output is zero");

    a_quot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sd[DVE].vld |-> (r_qc[DVE] <= 16'd16384) && (r_qs[DVE] <= 16'd16384))
        else $error("normalized component above one");

    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && o_result.bad_index) |->
            (o_result.pos_x == 16'sd0) && (o_result.pos_z == 16'sd0) &&
            (o_result.quat_w == 16'sd0) && (o_result.quat_z == 16'sd0))
        else $error("bad index result carries nonzero pose");

    a_w_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && !o_result.bad_index) |->
            (o_result.quat_w <= 16'sd16384) && (o_result.quat_w >= -16'sd16384))
        else $error("quaternion scalar out of range");

endmodule
